### src/i2crr_pkg.sv
// shared constants and types for the i2c register read master
`default_nettype none

package i2crr_pkg;

    localparam int PHASE_W    = 7;
    localparam int OFF_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int ADDR_W     = 7;
    localparam int BYTE_W     = 8;

    // interval boundaries of the transaction
    localparam logic [PHASE_W-1:0] P_ADDR_W     = 7'd3;
    localparam logic [PHASE_W-1:0] P_REG        = 7'd21;
    localparam logic [PHASE_W-1:0] P_RESTART    = 7'd39;
    localparam logic [PHASE_W-1:0] P_ADDR_R     = 7'd42;
    localparam logic [PHASE_W-1:0] P_READ       = 7'd60;
    localparam logic [PHASE_W-1:0] P_STOP       = 7'd78;
    localparam logic [PHASE_W-1:0] P_LAST       = 7'd79;

    localparam logic [OFF_W-1:0]   OFF_ACK      = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGISTER_INDEX = 2'd1;

    localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RST = 7'h10;
    localparam logic [BYTE_W-1:0]  REGISTER_INDEX_RST = 8'h01;

    typedef struct packed {
        logic scl;
        logic sda;
        logic sample;
    } bus_lvl_t;

endpackage

`default_nettype wire

### src/i2c_register_read_master.sv
// top level of the i2c register read master
`default_nettype none

// Each request is one bus delay interval and gives exactly one result: the
// SCL and SDA levels to drive in that interval, busy and done flags, and the
// last byte read. While the output register is empty or being emptied, one
// request is accepted every cycle; its result appears in the output register
// on the following cycle, and a new request is taken while that result waits.
// A read request while idle starts an 80-interval transaction (start, address
// with write bit, register index, repeated start, address with read bit,
// eight data bits with nack, stop); the phase counter advances once per
// accepted request, so a transaction spans 80 requests. Slave acks are not
// checked and clock stretching is not supported. Configuration writes are
// always ready; writes to an unknown index are dropped.
module i2c_register_read_master (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               read_request,
    input  wire logic                               sda_sample,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    scl_level,
    output logic                                    sda_level,
    output logic                                    busy_res,
    output logic                                    done_res,
    output logic [i2crr_pkg::BYTE_W-1:0]            read_byte,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [i2crr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [i2crr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import i2crr_pkg::*;

    logic [ADDR_W-1:0]  device_address_reg;
    logic [BYTE_W-1:0]  register_index_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               busy_reg;
    logic [BYTE_W-1:0]  shift_reg;
    logic [BYTE_W-1:0]  last_byte_reg;

    logic               out_valid_reg;
    logic               scl_reg;
    logic               sda_reg;
    logic               busy_res_reg;
    logic               done_reg;
    logic [BYTE_W-1:0]  read_byte_reg;

    logic               in_fire;
    logic               start;
    logic               busy_now;
    logic               last_phase;
    logic [PHASE_W-1:0] phase_cur;
    logic [BYTE_W-1:0]  shift_base;
    logic [BYTE_W-1:0]  shift_next;
    logic [BYTE_W-1:0]  last_byte_next;
    bus_lvl_t           lvl;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign start      = !busy_reg && read_request;
    assign busy_now   = busy_reg || read_request;
    assign phase_cur  = start ? '0 : phase_reg;
    assign shift_base = start ? '0 : shift_reg;
    assign last_phase = (phase_cur == P_LAST);

    i2crr_phase_decode u_decode (
        .phase          (phase_cur),
        .device_address (device_address_reg),
        .register_index (register_index_reg),
        .lvl            (lvl)
    );

    assign shift_next     = lvl.sample ? {shift_base[BYTE_W-2:0], sda_sample} : shift_base;
    assign last_byte_next = (busy_now && last_phase) ? shift_next : last_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RST;
            register_index_reg <= REGISTER_INDEX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data[ADDR_W-1:0];
                REG_REGISTER_INDEX: register_index_reg <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            busy_reg      <= 1'b0;
            shift_reg     <= '0;
            last_byte_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                if (busy_now)
                begin
                    shift_reg     <= shift_next;
                    last_byte_reg <= last_byte_next;
                    if (last_phase)
                    begin
                        busy_reg  <= 1'b0;
                        phase_reg <= '0;
                    end
                    else
                    begin
                        busy_reg  <= 1'b1;
                        phase_reg <= phase_cur + 7'd1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scl_reg       <= busy_now ? lvl.scl : 1'b1;
            sda_reg       <= busy_now ? lvl.sda : 1'b1;
            busy_res_reg  <= busy_now;
            done_reg      <= busy_now && last_phase;
            read_byte_reg <= last_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_level = scl_reg;
    assign sda_level = sda_reg;
    assign busy_res  = busy_res_reg;
    assign done_res  = done_reg;
    assign read_byte = read_byte_reg;

`ifndef NO_ASSERTIONS
    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (phase_reg == '0))
        else $error("phase counter nonzero while idle");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= P_LAST)
        else $error("phase counter past end of transaction");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (busy_res && scl_level && sda_level))
        else $error("done without final stop interval");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && busy_now && last_phase) |=> !busy_reg)
        else $error("transaction did not end after last interval");

    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && start) |=> (busy_reg && phase_reg == 7'd1))
        else $error("request while idle did not start transaction");
`endif

endmodule

`default_nettype wire

### src/i2crr_phase_decode.sv
// bus levels for one interval of the register read transaction
`default_nettype none

module i2crr_phase_decode (
    input  wire logic [i2crr_pkg::PHASE_W-1:0] phase,
    input  wire logic [i2crr_pkg::ADDR_W-1:0]  device_address,
    input  wire logic [i2crr_pkg::BYTE_W-1:0]  register_index,
    output i2crr_pkg::bus_lvl_t                lvl
);
    import i2crr_pkg::*;

    logic [PHASE_W-1:0] base;
    logic [PHASE_W-1:0] rel;
    logic [OFF_W-1:0]   off;
    logic [BYTE_W-1:0]  tx_byte;
    logic [2:0]         bit_idx;

    assign rel     = phase - base;
    assign off     = rel[OFF_W-1:0];
    assign bit_idx = 3'd7 - off[3:1];

    // first interval of the segment that holds the current phase
    always_comb
    begin
        if (phase < P_ADDR_W)
            base = '0;
        else if (phase < P_REG)
            base = P_ADDR_W;
        else if (phase < P_RESTART)
            base = P_REG;
        else if (phase < P_ADDR_R)
            base = P_RESTART;
        else if (phase < P_READ)
            base = P_ADDR_R;
        else if (phase < P_STOP)
            base = P_READ;
        else
            base = P_STOP;
    end

    always_comb
    begin
        tx_byte = {device_address, 1'b0};
        lvl.scl    = 1'b1;
        lvl.sda    = 1'b1;
        lvl.sample = 1'b0;
        if (phase < P_ADDR_W)
        begin
            lvl.scl = (off < 5'd2);
            lvl.sda = (off == 5'd0);
        end
        else if (phase < P_REG)
        begin
            tx_byte = {device_address, 1'b0};
            lvl.scl = off[0];
            lvl.sda = (off < OFF_ACK) ? tx_byte[bit_idx] : 1'b1;
        end
        else if (phase < P_RESTART)
        begin
            tx_byte = register_index;
            lvl.scl = off[0];
            lvl.sda = (off < OFF_ACK) ? tx_byte[bit_idx] : 1'b1;
        end
        else if (phase < P_ADDR_R)
        begin
            lvl.scl = (off < 5'd2);
            lvl.sda = (off == 5'd0);
        end
        else if (phase < P_READ)
        begin
            tx_byte = {device_address, 1'b1};
            lvl.scl = off[0];
            lvl.sda = (off < OFF_ACK) ? tx_byte[bit_idx] : 1'b1;
        end
        else if (phase < P_STOP)
        begin
            // data bits: scl high then low, sampled at end of high; then nack
            lvl.sda    = 1'b1;
            lvl.scl    = (off < OFF_ACK) ? ~off[0] : off[0];
            lvl.sample = (off < OFF_ACK) && !off[0];
        end
        else
        begin
            lvl.scl = 1'b1;
            lvl.sda = (phase != P_STOP);
        end
    end

endmodule

`default_nettype wire
